>>> sv/lqbm_pkg.sv
// Shared constants, types and helpers for the linked queue buffer manager.
package lqbm_pkg;

	// Pool size and derived widths; the value ENTRY_COUNT itself is the null link
	localparam int ENTRY_COUNT = 1024;
	localparam int IDX_W       = $clog2(ENTRY_COUNT);
	localparam int LINK_W      = $clog2(ENTRY_COUNT + 1);
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRY_COUNT);

	// Fixed transaction field widths
	localparam int OPC_W       = 2;
	localparam int IDX_FIELD_W = 10;

	typedef enum logic [OPC_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_APPEND = 2'd2,
		OP_TAKE   = 2'd3
	} opcode_t;

	localparam logic QSEL_DATA     = 1'b0;
	localparam logic QSEL_RESPONSE = 1'b1;

	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic init_wr;    // write one entry of the reset chain
		logic accept;     // capture the request and read the head's link
		logic step;       // main update of lists and link memory
		logic step2;      // second link write of an append
		logic load_fresh; // load output from this cycle's result
		logic load_held;  // load output from the held result
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic    init_last;
		opcode_t op;
		logic    out_free;
	} dp_stat_t;

	function automatic logic link_ok(input logic [LINK_W-1:0] l);
		return l < NULL_LINK;
	endfunction

endpackage

>>> sv/lqbm_if.sv
// Request and response channel interfaces.
interface lqbm_req_if;
	logic                                valid;
	logic                                ready;
	logic [lqbm_pkg::OPC_W-1:0]          opcode;
	logic                                queue_select;
	logic [lqbm_pkg::IDX_FIELD_W-1:0]    entry_index;

	modport source (output valid, output opcode, output queue_select, output entry_index,
		input ready);
	modport sink (input valid, input opcode, input queue_select, input entry_index,
		output ready);
endinterface

interface lqbm_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [lqbm_pkg::IDX_FIELD_W-1:0]    result_index;
	logic                                status;
	logic                                data_waiting;
	logic                                response_waiting;

	modport source (output valid, output result_index, output status, output data_waiting,
		output response_waiting, input ready);
	modport sink (input valid, input result_index, input status, input data_waiting,
		input response_waiting, output ready);
endinterface

>>> sv/linked_queue_buffer_manager.sv
// Top level of the linked queue buffer manager: controller plus datapath.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------------
//  req     | in  | valid / ready | opcode, queue_select, entry_index
//  rsp     | out | valid / ready | result_index, status, data_waiting, response_waiting
//
// The output register loads in the STEP state for alloc, free and take, and in
// STEP2 for append, whose two link writes share the one memory write port; a
// result that finds rsp still occupied waits in HOLD and loads from there.
// Alloc and take need the head's link from the synchronous link memory read.
// After reset an init sweep writes the reset chain into every link memory entry,
// with req.ready low. One transaction is worked at a time; a result waiting on
// rsp does not block acceptance, but the next result then waits for rsp.ready.
module linked_queue_buffer_manager (
	input  logic        clk,
	input  logic        arst_n,
	lqbm_req_if.sink    req,
	lqbm_rsp_if.source  rsp
);
	import lqbm_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	lqbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lqbm_dpath u_dpath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.req_opcode           (req.opcode),
		.req_queue_select     (req.queue_select),
		.req_entry_index      (req.entry_index),
		.rsp_valid            (rsp.valid),
		.rsp_ready            (rsp.ready),
		.rsp_result_index     (rsp.result_index),
		.rsp_status           (rsp.status),
		.rsp_data_waiting     (rsp.data_waiting),
		.rsp_response_waiting (rsp.response_waiting)
	);

endmodule

>>> sv/lqbm_ctrl.sv
// Controller state machine: link memory init sweep and per-transaction sequencing.
module lqbm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  lqbm_pkg::dp_stat_t    stat,
	output lqbm_pkg::ctrl_cmd_t   cmd
);
	import lqbm_pkg::*;

	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_STEP  = 5'b00100,
		ST_STEP2 = 5'b01000,
		ST_HOLD  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (stat.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (stat.op == OP_APPEND) begin
					state_d = ST_STEP2;
				end else if (stat.out_free) begin
					cmd.load_fresh = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_STEP2: begin
				cmd.step2 = 1'b1;
				if (stat.out_free) begin
					cmd.load_fresh = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (stat.out_free) begin
					cmd.load_held = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

>>> sv/lqbm_dpath.sv
// Datapath: link memory, list head and tail registers, result and output registers.
module lqbm_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lqbm_pkg::ctrl_cmd_t                 cmd,
	output lqbm_pkg::dp_stat_t                  stat,
	input  logic [lqbm_pkg::OPC_W-1:0]          req_opcode,
	input  logic                                req_queue_select,
	input  logic [lqbm_pkg::IDX_FIELD_W-1:0]    req_entry_index,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [lqbm_pkg::IDX_FIELD_W-1:0]    rsp_result_index,
	output logic                                rsp_status,
	output logic                                rsp_data_waiting,
	output logic                                rsp_response_waiting
);
	import lqbm_pkg::*;

	// Link memory: one next link per entry
	logic [LINK_W-1:0] link_mem [ENTRY_COUNT];
	logic [LINK_W-1:0] rdata_q;
	logic              we;
	logic [IDX_W-1:0]  wa;
	logic [LINK_W-1:0] wd;
	logic [IDX_W-1:0]  rd_idx;

	// Captured request
	opcode_t              op_q;
	logic                 qsel_q;
	logic [IDX_FIELD_W-1:0] eidx_q;

	// List pointers
	logic [LINK_W-1:0] free_head_q, free_head_d;
	logic [LINK_W-1:0] dhead_q, dhead_d, dtail_q, dtail_d;
	logic [LINK_W-1:0] rhead_q, rhead_d, rtail_q, rtail_d;

	// Init sweep counter
	logic [IDX_W-1:0] init_cnt_q;

	// Held result
	logic [IDX_FIELD_W-1:0] res_idx_d, res_idx_q;
	logic                   res_stat_d, res_stat_q;

	// Output register
	logic                   out_valid_q;
	logic [IDX_FIELD_W-1:0] out_idx_q;
	logic                   out_stat_q, out_dw_q, out_rw_q;

	// Working values
	logic [LINK_W-1:0] qh, qt, qh_new, qt_new, nxt, e_link;
	logic [IDX_W-1:0]  e_idx;
	logic              e_ok;
	opcode_t           req_op;

	assign req_op = opcode_t'(req_opcode);
	assign e_ok   = 32'(eidx_q) < 32'(ENTRY_COUNT);
	assign e_link = LINK_W'(eidx_q);
	assign e_idx  = IDX_W'(eidx_q);
	assign qh     = (qsel_q == QSEL_RESPONSE) ? rhead_q : dhead_q;
	assign qt     = (qsel_q == QSEL_RESPONSE) ? rtail_q : dtail_q;
	assign nxt    = link_ok(rdata_q) ? rdata_q : NULL_LINK;

	// Head read address chosen from the incoming opcode
	always_comb begin
		if (req_op == OP_ALLOC) begin
			rd_idx = IDX_W'(free_head_q);
		end else if (req_queue_select == QSEL_RESPONSE) begin
			rd_idx = IDX_W'(rhead_q);
		end else begin
			rd_idx = IDX_W'(dhead_q);
		end
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[wa] <= wd;
		end
		if (cmd.accept) begin
			rdata_q <= link_mem[rd_idx];
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= req_op;
			qsel_q <= req_queue_select;
			eidx_q <= req_entry_index;
		end
	end

	// Operation decode: memory write, pointer updates, result
	always_comb begin
		we          = 1'b0;
		wa          = '0;
		wd          = NULL_LINK;
		free_head_d = free_head_q;
		qh_new      = qh;
		qt_new      = qt;
		res_idx_d   = '0;
		res_stat_d  = STATUS_DONE;
		if (cmd.init_wr) begin
			we = 1'b1;
			wa = init_cnt_q;
			wd = LINK_W'(init_cnt_q) + 1'b1;
		end else if (cmd.step) begin
			unique case (op_q)
				OP_ALLOC: begin
					if (link_ok(free_head_q)) begin
						we          = 1'b1;
						wa          = IDX_W'(free_head_q);
						free_head_d = nxt;
						res_idx_d   = IDX_FIELD_W'(free_head_q);
					end else begin
						res_stat_d = STATUS_EMPTY;
					end
				end
				OP_FREE: begin
					if (e_ok) begin
						we          = 1'b1;
						wa          = e_idx;
						wd          = link_ok(free_head_q) ? free_head_q : NULL_LINK;
						free_head_d = e_link;
					end
				end
				OP_APPEND: begin
					if (e_ok) begin
						if (link_ok(qh)) begin
							// tail link is skipped when the tail is broken
							if (link_ok(qt)) begin
								we = 1'b1;
								wa = IDX_W'(qt);
								wd = e_link;
							end
							qt_new = e_link;
						end else begin
							qh_new = e_link;
							qt_new = e_link;
						end
					end
				end
				OP_TAKE: begin
					if (link_ok(qh)) begin
						we        = 1'b1;
						wa        = IDX_W'(qh);
						qh_new    = nxt;
						res_idx_d = IDX_FIELD_W'(qh);
						if (!link_ok(rdata_q)) begin
							qt_new = NULL_LINK;
						end
					end else begin
						res_stat_d = STATUS_EMPTY;
					end
				end
				default: begin
					res_stat_d = STATUS_DONE;
				end
			endcase
		end else if (cmd.step2) begin
			// appended entry terminates its queue
			if (e_ok) begin
				we = 1'b1;
				wa = e_idx;
			end
		end
	end

	// Route the selected queue's new pointers
	always_comb begin
		dhead_d = dhead_q;
		dtail_d = dtail_q;
		rhead_d = rhead_q;
		rtail_d = rtail_q;
		if (qsel_q == QSEL_RESPONSE) begin
			rhead_d = qh_new;
			rtail_d = qt_new;
		end else begin
			dhead_d = qh_new;
			dtail_d = qt_new;
		end
	end

	// Pointer registers and init counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			dhead_q     <= NULL_LINK;
			dtail_q     <= NULL_LINK;
			rhead_q     <= NULL_LINK;
			rtail_q     <= NULL_LINK;
			init_cnt_q  <= '0;
		end else begin
			free_head_q <= free_head_d;
			dhead_q     <= dhead_d;
			dtail_q     <= dtail_d;
			rhead_q     <= rhead_d;
			rtail_q     <= rtail_d;
			if (cmd.init_wr) begin
				init_cnt_q <= init_cnt_q + 1'b1;
			end
		end
	end

	// Held result for a stalled output
	always_ff @(posedge clk) begin
		if (cmd.step || cmd.step2) begin
			res_idx_q  <= res_idx_d;
			res_stat_q <= res_stat_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_fresh || cmd.load_held) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_fresh) begin
			out_idx_q  <= res_idx_d;
			out_stat_q <= res_stat_d;
		end else if (cmd.load_held) begin
			out_idx_q  <= res_idx_q;
			out_stat_q <= res_stat_q;
		end
		if (cmd.load_fresh || cmd.load_held) begin
			out_dw_q <= link_ok(dhead_d);
			out_rw_q <= link_ok(rhead_d);
		end
	end

	assign rsp_valid            = out_valid_q;
	assign rsp_result_index     = out_idx_q;
	assign rsp_status           = out_stat_q;
	assign rsp_data_waiting     = out_dw_q;
	assign rsp_response_waiting = out_rw_q;

	assign stat.init_last = (init_cnt_q == IDX_W'(ENTRY_COUNT - 1));
	assign stat.op        = op_q;
	assign stat.out_free  = !out_valid_q || rsp_ready;

endmodule

>>> sv/lqbm_checker.sv
// Port-level checker for the linked queue buffer manager, with its bind.
module lqbm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [lqbm_pkg::IDX_FIELD_W-1:0]    rsp_result_index,
	input logic                                rsp_status
);
	import lqbm_pkg::*;

	// a result held on rsp stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped before the transaction completed");

	// an empty-list result gives no entry
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STATUS_EMPTY) |-> rsp_result_index == '0)
		else $error("empty status with a non-zero result index");

	// one transaction at a time: no acceptance right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted in back-to-back cycles");

	// a fresh result follows an acceptance through STEP, or through STEP and STEP2
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2)
			|| $past(req_valid && req_ready, 3))
		else $error("result appeared without a matching request");

endmodule

bind linked_queue_buffer_manager lqbm_checker u_lqbm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_result_index (rsp.result_index),
	.rsp_status       (rsp.status)
);

>>> tb/sv/linked_queue_buffer_manager_tb.sv
// Self-checking testbench for the linked queue buffer manager.
module linked_queue_buffer_manager_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lqbm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;

	// One response as the block should give it
	typedef struct packed {
		logic [IDX_FIELD_W-1:0] result_index;
		logic                   status;
		logic                   data_waiting;
		logic                   response_waiting;
	} outcome_t;

	logic clk;
	logic arst_n;

	lqbm_req_if req_ch ();
	lqbm_rsp_if rsp_ch ();

	linked_queue_buffer_manager dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Pool state as predicted by the testbench
	logic [LINK_W-1:0] link_mem [ENTRY_COUNT];
	logic [LINK_W-1:0] free_top;
	logic [LINK_W-1:0] data_first;
	logic [LINK_W-1:0] data_last;
	logic [LINK_W-1:0] resp_first;
	logic [LINK_W-1:0] resp_last;

	outcome_t pending_outcomes [$];
	int       held_entries [$];
	int       mismatch_count;
	int       cycle_count;
	int       rx_hold_left;
	bit       tx_gaps_on;
	bit       rx_gaps_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit in_pool(input logic [LINK_W-1:0] link);
		return link < LINK_W'(ENTRY_COUNT);
	endfunction

	function automatic void reset_pool();
		for (int i = 0; i < ENTRY_COUNT; i++)
			link_mem[i] = LINK_W'(i + 1);
		link_mem[ENTRY_COUNT-1] = NULL_LINK;
		free_top   = '0;
		data_first = NULL_LINK;
		data_last  = NULL_LINK;
		resp_first = NULL_LINK;
		resp_last  = NULL_LINK;
	endfunction

	// Apply one operation to the predicted pool and return the response it gives
	function automatic outcome_t pool_update(input opcode_t op, input logic qsel,
		input logic [IDX_FIELD_W-1:0] idx);
		outcome_t          res;
		logic [LINK_W-1:0] first;
		logic [LINK_W-1:0] last;
		logic [LINK_W-1:0] given;
		res   = '0;
		first = (qsel == QSEL_RESPONSE) ? resp_first : data_first;
		last  = (qsel == QSEL_RESPONSE) ? resp_last : data_last;
		case (op)
			OP_ALLOC: begin
				if (in_pool(free_top)) begin
					given    = free_top;
					free_top = link_mem[given];
					if (!in_pool(free_top))
						free_top = NULL_LINK;
					link_mem[given]  = NULL_LINK;
					res.result_index = given[IDX_FIELD_W-1:0];
				end else begin
					res.status = STATUS_EMPTY;
				end
			end
			OP_FREE: begin
				link_mem[idx] = in_pool(free_top) ? free_top : NULL_LINK;
				free_top      = LINK_W'(idx);
			end
			OP_APPEND: begin
				if (in_pool(first)) begin
					// a null tail under a live head skips the link write
					if (in_pool(last))
						link_mem[last] = LINK_W'(idx);
					last = LINK_W'(idx);
				end else begin
					first = LINK_W'(idx);
					last  = LINK_W'(idx);
				end
				link_mem[idx] = NULL_LINK;
			end
			default: begin
				if (in_pool(first)) begin
					given = first;
					first = link_mem[given];
					if (!in_pool(first)) begin
						first = NULL_LINK;
						last  = NULL_LINK;
					end
					link_mem[given]  = NULL_LINK;
					res.result_index = given[IDX_FIELD_W-1:0];
				end else begin
					res.status = STATUS_EMPTY;
				end
			end
		endcase
		if (op == OP_APPEND || op == OP_TAKE) begin
			if (qsel == QSEL_RESPONSE) begin
				resp_first = first;
				resp_last  = last;
			end else begin
				data_first = first;
				data_last  = last;
			end
		end
		res.data_waiting     = in_pool(data_first);
		res.response_waiting = in_pool(resp_first);
		return res;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Drive one request transaction and record what it should produce
	task automatic send_op(input opcode_t op, input logic qsel,
		input logic [IDX_FIELD_W-1:0] idx);
		int       gap;
		int       found [$];
		outcome_t res;
		gap = tx_gaps_on ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= op;
		req_ch.queue_select <= qsel;
		req_ch.entry_index  <= idx;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		res = pool_update(op, qsel, idx);
		pending_outcomes.push_back(res);
		// keep track of entries the stimulus owns outright
		if ((op == OP_ALLOC || op == OP_TAKE) && res.status == STATUS_DONE) begin
			found = held_entries.find_first_index(e) with (e == int'(res.result_index));
			if (found.size() == 0)
				held_entries.push_back(int'(res.result_index));
		end else if (op == OP_FREE || op == OP_APPEND) begin
			found = held_entries.find_first_index(e) with (e == int'(idx));
			if (found.size() != 0)
				held_entries.delete(found[0]);
		end
	endtask

	// Sender stops and waits for every outstanding response
	task automatic pause_until_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// One item, mostly a well-formed use of owned entries; bias favours filling
	task automatic send_random(input int bias);
		int                     r;
		opcode_t                op;
		logic                   qsel;
		logic [IDX_FIELD_W-1:0] idx;
		qsel = 1'($urandom_range(0, 1));
		idx  = IDX_FIELD_W'($urandom_range(0, ENTRY_COUNT - 1));
		r    = $urandom_range(0, 99);
		if (r < 12) begin
			// noise: any operation on any entry
			op = opcode_t'($urandom_range(0, 3));
		end else begin
			r = $urandom_range(0, 99);
			if (r < bias)
				op = (r < bias / 2) ? OP_ALLOC : OP_APPEND;
			else
				op = (r < bias + (100 - bias) / 2) ? OP_TAKE : OP_FREE;
			if ((op == OP_APPEND || op == OP_FREE) && held_entries.size() == 0)
				op = OP_ALLOC;
			if (op == OP_APPEND || op == OP_FREE)
				idx = IDX_FIELD_W'(held_entries[$urandom_range(0, held_entries.size() - 1)]);
		end
		send_op(op, qsel, idx);
	endtask

	// Empty lists, the full index range and misuse that cuts the free list short
	task automatic test_directed_lists();
		send_op(OP_TAKE, QSEL_DATA, 10'd0);
		send_op(OP_TAKE, QSEL_RESPONSE, 10'd1023);
		send_op(OP_ALLOC, QSEL_DATA, 10'd0);
		send_op(OP_ALLOC, QSEL_RESPONSE, 10'd1023);
		send_op(OP_APPEND, QSEL_DATA, 10'd0);
		send_op(OP_APPEND, QSEL_RESPONSE, 10'd1);
		// entry 5 still on the free list: appending it ends the free chain there
		send_op(OP_APPEND, QSEL_DATA, 10'd5);
		repeat (4)
			send_op(OP_ALLOC, QSEL_DATA, 10'd0);
		send_op(OP_ALLOC, QSEL_RESPONSE, 10'd1023);
		repeat (3)
			send_op(OP_TAKE, QSEL_DATA, 10'd1023);
		send_op(OP_TAKE, QSEL_RESPONSE, 10'd0);
		send_op(OP_FREE, QSEL_DATA, 10'd1023);
		send_op(OP_FREE, QSEL_RESPONSE, 10'd0);
		repeat (3)
			send_op(OP_ALLOC, QSEL_DATA, 10'd0);
		send_op(OP_APPEND, QSEL_RESPONSE, 10'd1023);
		send_op(OP_APPEND, QSEL_RESPONSE, 10'd682);
		// free an entry still queued: it is relinked with no check
		send_op(OP_FREE, QSEL_DATA, 10'd682);
		send_op(OP_TAKE, QSEL_RESPONSE, 10'd341);
		send_op(OP_FREE, QSEL_DATA, 10'd341);
	endtask

	// Put untouched entries back on the free list so the lists can grow
	task automatic test_refill_pool();
		for (int i = 6; i < 46; i++)
			send_op(OP_FREE, 1'($urandom_range(0, 1)), IDX_FIELD_W'(i));
		pause_until_drained();
	endtask

	task automatic test_random_mix(input int count, input int bias, input bit gaps);
		tx_gaps_on = gaps;
		rx_gaps_on = gaps;
		repeat (count)
			send_random(bias);
		pause_until_drained();
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// Receiver holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		rx_hold_left = 80;
		tx_gaps_on   = 1'b0;
		repeat (12)
			send_random(50);
		tx_gaps_on = 1'b1;
		pause_until_drained();
	endtask

	// Response sink: random ready gaps plus an optional long hold
	initial begin
		int gap_left;
		gap_left     = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_hold_left--;
			end else if (gap_left > 0) begin
				rsp_ch.ready <= 1'b0;
				gap_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rx_gaps_on)
					gap_left = pick_gap();
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			if (mismatch_count < 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each response transaction with the oldest prediction
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: response with nothing pending", $realtime);
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("result_index", want.result_index, rsp_ch.result_index);
				check_field("status", want.status, rsp_ch.status);
				check_field("data_waiting", want.data_waiting, rsp_ch.data_waiting);
				check_field("response_waiting", want.response_waiting,
					rsp_ch.response_waiting);
			end
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		req_ch.valid        = 1'b0;
		req_ch.opcode       = OP_ALLOC;
		req_ch.queue_select = QSEL_DATA;
		req_ch.entry_index  = '0;
		arst_n              = 1'b0;
		mismatch_count      = 0;
		rx_hold_left        = 0;
		tx_gaps_on          = 1'b1;
		rx_gaps_on          = 1'b1;
		reset_pool();
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_lists();
		test_refill_pool();
		test_random_mix(130, 70, 1'b1);
		test_backpressure();
		test_random_mix(130, 50, 1'b0);
		test_random_mix(130, 25, 1'b1);

		pause_until_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
sv/lqbm_pkg.sv
sv/lqbm_if.sv
sv/lqbm_ctrl.sv
sv/lqbm_dpath.sv
sv/linked_queue_buffer_manager.sv
sv/lqbm_checker.sv
tb/sv/linked_queue_buffer_manager_tb.sv
